>>> hdl/dwcc_pkg.sv
// dwcc_pkg: shared constants, types and register map of the distance window
// credibility check. No dependencies; imported by every module of the block.
package dwcc_pkg;

  // Window store depth and derived widths
  localparam int WINDOW_DEPTH = 128;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int COV_SUM_W    = 16 + PTR_W;
  localparam int PROD_W       = 16 + CNT_W;
  localparam int DIST_W       = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // APB port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values
  localparam logic [15:0] WINDOW_LENGTH_RST = 16'd768;   // 3.0 in Q8.8
  localparam logic [7:0]  MIN_POINTS_RST    = 8'd40;
  localparam logic [7:0]  REINIT_LIMIT_RST  = 8'd3;
  localparam logic [15:0] COV_LIMIT_RST     = 16'd2458;  // 0.6 in Q4.12

  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_MIN_POINTS    = 3'd1,
    REG_REINIT_LIMIT  = 3'd2,
    REG_COV_X_LIMIT   = 3'd3,
    REG_COV_Y_LIMIT   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] window_length;
    logic [7:0]  min_points;
    logic [7:0]  reinit_limit;
    logic [15:0] cov_x_limit;
    logic [15:0] cov_y_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] step_dist;
    logic [15:0] cov_x;
    logic [15:0] cov_y;
    logic        mark;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // take the input word, add its distance
    logic pop;      // evict the oldest point
    logic ct_upd;   // eviction-loop pop: count under test follows held count
    logic append;   // write the new point at the tail
    logic prod;     // form limit * count products
    logic result;   // load the output register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic loop_go;
  } dp_status_t;

endpackage

>>> hdl/distance_window_credibility_check_core.sv
// Distance window credibility check: top level, joins registers, sequencer and
// datapath. Depends on dwcc_pkg, dwcc_regs, dwcc_ctrl, dwcc_datapath.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one localization point per
//   word: step distance (Q8.8), x/y covariance (Q4.12) and reinit mark.
//   Output channel (out_valid_o/out_ready_i) returns one word per point:
//   credible flag, marks in window, points held and window distance.
//   Configuration is written over the APB port while the block is idle;
//   registers sit at byte addresses 0, 4, 8, 12, 16.
// Sequence:
//   An accepted point passes through FULL_POP (only when the window is full
//   on arrival), APPEND, CHECK, PROD and RESULT back to IDLE; CHECK repeats
//   for each eviction-loop pop (one per cycle, one window store read each).
//   The result is loaded into the output register in RESULT once it is free.
// Reset:
//   Window empty, sums zero, registers at defaults. The store itself is not
// cleared; only held entries are ever used.
// Stall:
//   A result waits in the output register; the next point is still taken.
//   A second result waits in the sequencer until the first is taken.
module distance_window_credibility_check_core
  import dwcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       step_distance_i,
  input  logic [15:0]       cov_x_i,
  input  logic [15:0]       cov_y_i,
  input  logic              reinit_mark_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              credible_o,
  output logic [7:0]        reinit_count_o,
  output logic [7:0]        points_held_o,
  output logic [DIST_W-1:0] window_distance_o
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  dwcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dwcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dwcc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .status_o          (status),
    .step_distance_i   (step_distance_i),
    .cov_x_i           (cov_x_i),
    .cov_y_i           (cov_y_i),
    .reinit_mark_i     (reinit_mark_i),
    .credible_o        (credible_o),
    .reinit_count_o    (reinit_count_o),
    .points_held_o     (points_held_o),
    .window_distance_o (window_distance_o)
  );

endmodule

>>> hdl/dwcc_regs.sv
// dwcc_regs: APB configuration registers of the credibility check.
// Depends on dwcc_pkg (register map, reset values, cfg_t).
module dwcc_regs
  import dwcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= WINDOW_LENGTH_RST;
      cfg_q.min_points    <= MIN_POINTS_RST;
      cfg_q.reinit_limit  <= REINIT_LIMIT_RST;
      cfg_q.cov_x_limit   <= COV_LIMIT_RST;
      cfg_q.cov_y_limit   <= COV_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_WINDOW_LENGTH: cfg_q.window_length <= pwdata[15:0];
        REG_MIN_POINTS:    cfg_q.min_points    <= pwdata[7:0];
        REG_REINIT_LIMIT:  cfg_q.reinit_limit  <= pwdata[7:0];
        REG_COV_X_LIMIT:   cfg_q.cov_x_limit   <= pwdata[15:0];
        REG_COV_Y_LIMIT:   cfg_q.cov_y_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_WINDOW_LENGTH: prdata = DATA_W'(cfg_q.window_length);
      REG_MIN_POINTS:    prdata = DATA_W'(cfg_q.min_points);
      REG_REINIT_LIMIT:  prdata = DATA_W'(cfg_q.reinit_limit);
      REG_COV_X_LIMIT:   prdata = DATA_W'(cfg_q.cov_x_limit);
      REG_COV_Y_LIMIT:   prdata = DATA_W'(cfg_q.cov_y_limit);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> hdl/dwcc_ctrl.sv
// dwcc_ctrl: sequencer of the credibility check; owns the handshakes and
// drives the datapath. Depends on dwcc_pkg (dp_cmd_t, dp_status_t).
module dwcc_ctrl
  import dwcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FULL_POP,
    S_APPEND,
    S_CHECK,
    S_PROD,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.pop    = (state_q == S_FULL_POP) || ((state_q == S_CHECK) && status_i.loop_go);
    cmd_o.ct_upd = (state_q == S_CHECK) && status_i.loop_go;
    cmd_o.append = (state_q == S_APPEND);
    cmd_o.prod   = (state_q == S_PROD);
    cmd_o.result = (state_q == S_RESULT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= status_i.full ? S_FULL_POP : S_APPEND;
          end
        end
        S_FULL_POP: state_q <= S_APPEND;
        S_APPEND:   state_q <= S_CHECK;
        S_CHECK: begin
          if (!status_i.loop_go) begin
            state_q <= S_PROD;
          end
        end
        S_PROD:     state_q <= S_RESULT;
        S_RESULT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a word is taken only between results, never while the window is being updated
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_FULL_POP || state_q == S_APPEND))
    else $error("load did not start an update");
`endif

endmodule

>>> hdl/dwcc_datapath.sv
// dwcc_datapath: window store, running sums, eviction and threshold tests.
// Depends on dwcc_pkg (widths, entry_t, cfg_t, command and status structs).
module dwcc_datapath
  import dwcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [15:0]       step_distance_i,
  input  logic [15:0]       cov_x_i,
  input  logic [15:0]       cov_y_i,
  input  logic              reinit_mark_i,
  output logic              credible_o,
  output logic [7:0]        reinit_count_o,
  output logic [7:0]        points_held_o,
  output logic [DIST_W-1:0] window_distance_o
);

  entry_t mem [WINDOW_DEPTH];
  entry_t rd_q;
  entry_t new_q;

  logic [PTR_W-1:0]     head_q, head_d, tail_q;
  logic [CNT_W-1:0]     held_q, count_test_q, mark_q;
  logic [DIST_W-1:0]    dist_q;
  logic [COV_SUM_W-1:0] cov_x_q, cov_y_q;
  logic [PROD_W-1:0]    prod_x_q, prod_y_q;

  logic [DIST_W:0]      dist_add;
  logic [DIST_W-1:0]    dist_sat;
  logic                 ok;

  logic              credible_q;
  logic [7:0]        reinit_count_q, points_held_q;
  logic [DIST_W-1:0] window_distance_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign dist_add = {1'b0, dist_q} + (DIST_W + 1)'(step_distance_i);
  assign dist_sat = dist_add[DIST_W] ? DIST_MAX : dist_add[DIST_W-1:0];

  assign status_o.full    = held_q >= CNT_W'(WINDOW_DEPTH);
  assign status_o.loop_go = (dist_q > DIST_W'(cfg_i.window_length))
                         && (16'(count_test_q) > 16'(cfg_i.min_points))
                         && (held_q > CNT_W'(1));

  // read port follows the head so rd_q holds the oldest point whenever a pop uses it
  assign head_d = cmd_i.pop ? ptr_next(head_q) : head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[tail_q] <= new_q;
    end
    rd_q <= mem[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      held_q       <= '0;
      count_test_q <= '0;
      mark_q       <= '0;
      dist_q       <= '0;
      cov_x_q      <= '0;
      cov_y_q      <= '0;
    end else begin
      head_q <= head_d;
      if (cmd_i.load) begin
        dist_q       <= dist_sat;
        count_test_q <= held_q;
      end
      if (cmd_i.pop) begin
        dist_q  <= (dist_q >= DIST_W'(rd_q.step_dist)) ? dist_q - DIST_W'(rd_q.step_dist) : '0;
        cov_x_q <= cov_x_q - COV_SUM_W'(rd_q.cov_x);
        cov_y_q <= cov_y_q - COV_SUM_W'(rd_q.cov_y);
        held_q  <= held_q - CNT_W'(1);
        if (rd_q.mark && (mark_q != '0)) begin
          mark_q <= mark_q - CNT_W'(1);
        end
        if (cmd_i.ct_upd) begin
          count_test_q <= held_q - CNT_W'(1);
        end
      end
      if (cmd_i.append) begin
        tail_q  <= ptr_next(tail_q);
        held_q  <= held_q + CNT_W'(1);
        cov_x_q <= cov_x_q + COV_SUM_W'(new_q.cov_x);
        cov_y_q <= cov_y_q + COV_SUM_W'(new_q.cov_y);
        mark_q  <= mark_q + CNT_W'(new_q.mark);
      end
    end
  end

  // mean tests as sum > limit * count
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_q.step_dist <= step_distance_i;
      new_q.cov_x     <= cov_x_i;
      new_q.cov_y     <= cov_y_i;
      new_q.mark      <= reinit_mark_i;
    end
    if (cmd_i.prod) begin
      prod_x_q <= PROD_W'(cfg_i.cov_x_limit) * PROD_W'(held_q);
      prod_y_q <= PROD_W'(cfg_i.cov_y_limit) * PROD_W'(held_q);
    end
    if (cmd_i.result) begin
      credible_q        <= ok;
      reinit_count_q    <= 8'(mark_q);
      points_held_q     <= 8'(held_q);
      window_distance_q <= dist_q;
    end
  end

  assign ok = !(16'(mark_q) >= 16'(cfg_i.reinit_limit))
           && !(PROD_W'(cov_x_q) > prod_x_q)
           && !(PROD_W'(cov_y_q) > prod_y_q);

  assign credible_o        = credible_q;
  assign reinit_count_o    = reinit_count_q;
  assign points_held_o     = points_held_q;
  assign window_distance_o = window_distance_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(WINDOW_DEPTH))
    else $error("held count above window depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (held_q != '0))
    else $error("eviction from empty window");

  a_marks_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= held_q)
    else $error("mark count above held count");
`endif

endmodule
